FILE: rtl/cms_pkg.sv
// Shared types and constants for the count-min sketch update block.
`default_nettype none
package cms_pkg;

  localparam int HASH_W        = 6;
  localparam int HASH_VALS     = 1 << HASH_W;
  localparam int WORDS_PER_ROW = 16;
  localparam int LAST_WORD     = 15;
  localparam int HASH_KEY_BITS = 16;
  localparam int TABLE_ROWS    = 4;
  localparam int AMOUNT_W      = 16;
  localparam int RESULT_W      = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_LIMIT = 2'd1;

  typedef enum logic [1:0] {
    ACT_INC   = 2'd0,
    ACT_EST   = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef struct packed {
    action_t               action;
    logic [15:0]           key;
    logic [3:0]            group;
    logic [AMOUNT_W-1:0]   amount;
    logic [1:0]            table_row;
    logic [3:0]            key_bit;
    logic [HASH_W-1:0]     table_word;
  } item_t;

  typedef struct packed {
    logic [RESULT_W-1:0] count_estimate;
    logic                skipped;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_step;
    logic capture;
    logic decode;
    logic load;
    logic min_step;
    logic update;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    action_t action;
    logic    skip;
    logic    min_last;
    logic    clear_last;
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/count_min_sketch_update_top.sv
// Top level of the count-min sketch update block.
//
// Command channel: an item (item) is taken at a clock edge with start high
// and busy low. Actions: increment, estimate, hash-word write, unused.
// Each item yields one result beat on result, flagged by done for exactly
// one cycle; the receiver must take it then, there is no back-pressure.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data. Index
// 0 is update_mode, index 1 is group_limit. cfg_ready is always high;
// write only while the block is idle.
// Sequence after the accept edge: decode; hash writes, unused actions and
// filtered items then finish. Estimates go on through the read of the
// counter RAMs, a load of the read words and a minimum scan over the rows;
// increments then update the counters and scan again before finishing.
// busy drops the cycle after done. The length of an item is set by the
// row-serial minimum scan (one row per cycle, run once before and once
// after the update) and by the registered read of the per-row counter RAMs.
// Reset: synchronous, active high. Afterwards a clearing sweep writes zero
// to all counters, one column per cycle in all rows at once, with busy
// high. Hash words and config registers clear at once.
`default_nettype none
module count_min_sketch_update_top
  import cms_pkg::*;
#(
  parameter int ROWS       = 4,
  parameter int COLS       = 64,
  parameter int COUNT_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output      logic                  busy,
  input  wire item_t                 item,
  output      logic                  done,
  output      result_t               result,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t st;

  // config registers accept a beat every cycle
  assign cfg_ready = 1'b1;

  cms_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  cms_datapath #(
    .ROWS       (ROWS),
    .COLS       (COLS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .result    (result)
  );

endmodule
`default_nettype wire

FILE: rtl/cms_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/cms_ctrl.sv
// Sequencer for the sketch: clearing sweep, decode, read, min scans, update.
`default_nettype none
module cms_ctrl
  import cms_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire status_t st,
  output      cmd_t    cmd,
  output      logic    busy,
  output      logic    done
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_READ,
    S_LOAD,
    S_MIN,
    S_UPD,
    S_MIN2,
    S_DONE
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start && !busy) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        case (st.action)
          ACT_INC, ACT_EST: state_next = st.skip ? S_DONE : S_READ;
          default:          state_next = S_DONE;
        endcase
      end
      S_READ: state_next = S_LOAD;
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_MIN;
      end
      S_MIN: begin
        cmd.min_step = 1'b1;
        if (st.min_last) state_next = (st.action == ACT_INC) ? S_UPD : S_DONE;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_MIN2;
      end
      S_MIN2: begin
        cmd.min_step = 1'b1;
        if (st.min_last) state_next = S_DONE;
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
      done  <= (state_next == S_DONE);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/cms_datapath.sv
// Sketch datapath: config regs, hash words, per-row counter RAMs, min and update.
`default_nettype none
module cms_datapath
  import cms_pkg::*;
#(
  parameter int ROWS       = 4,
  parameter int COLS       = 64,
  parameter int COUNT_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire item_t                 item,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire cmd_t                  cmd,
  output      status_t               st,
  output      result_t               result
);

  localparam int CW    = $clog2(COLS);
  localparam int RIW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SUM_W = ((COUNT_BITS > AMOUNT_W) ? COUNT_BITS : AMOUNT_W) + 1;

  logic                  update_mode;
  logic [2:0]            group_limit;
  item_t                 it;
  logic [HASH_W-1:0]     hw [ROWS][WORDS_PER_ROW];
  logic [HASH_W-1:0]     hsh [ROWS];
  logic [CW-1:0]         mod_tab [HASH_VALS];
  logic [CW-1:0]         col [ROWS];
  logic [COUNT_BITS-1:0] rdata [ROWS];
  logic [COUNT_BITS-1:0] val [ROWS];
  logic [COUNT_BITS-1:0] upd [ROWS];
  logic [ROWS-1:0]       sel;
  logic [COUNT_BITS-1:0] mn, mn_next;
  logic [RIW-1:0]        row_idx;
  logic [CW-1:0]         clr_addr;
  logic [RESULT_W-1:0]   est32;
  logic                  skip;
  logic                  min_last;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      update_mode <= 1'b0;
      group_limit <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UPDATE_MODE: update_mode <= cfg_data[0];
        CFG_GROUP_LIMIT: group_limit <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) it <= item;
  end

  // group filter applies to increment and estimate only
  always_comb begin
    skip = 1'b0;
    if ((it.action == ACT_INC) || (it.action == ACT_EST)) begin
      skip = (group_limit inside {[3'd1:3'd4]}) && (it.group > {1'b0, group_limit});
    end
  end

  // hash words; only the rows table_row can address are writable
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        for (int w = 0; w < WORDS_PER_ROW; w++) begin
          hw[r][w] <= '0;
        end
      end
    end else if (cmd.decode && (it.action == ACT_WRITE)) begin
      for (int r = 0; r < ROWS; r++) begin
        if ((r < TABLE_ROWS) && (it.table_row == 2'(r))) begin
          hw[r][it.key_bit] <= it.table_word;
        end
      end
    end
  end

  // H3: key bit k picks word LAST_WORD-k
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      hsh[r] = '0;
      for (int k = 0; k < HASH_KEY_BITS; k++) begin
        if (it.key[k]) hsh[r] = hsh[r] ^ hw[r][LAST_WORD-k];
      end
    end
  end

  // hash value modulo COLS as a constant table
  for (genvar v = 0; v < HASH_VALS; v++) begin : g_mod
    localparam int MV = v % COLS;
    assign mod_tab[v] = CW'(MV);
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      for (int r = 0; r < ROWS; r++) begin
        col[r] <= mod_tab[hsh[r]];
      end
    end
  end

  // per-row counter lanes
  for (genvar r = 0; r < ROWS; r++) begin : g_row
    logic [SUM_W-1:0] sum;

    assign sum    = SUM_W'(val[r]) + SUM_W'(it.amount);
    assign upd[r] = (|sum[SUM_W-1:COUNT_BITS]) ? '1 : sum[COUNT_BITS-1:0];
    assign sel[r] = !update_mode || (val[r] == mn);

    cms_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (COLS)
    ) u_ram (
      .clk   (clk),
      .we    (cmd.clear_step || (cmd.update && sel[r])),
      .waddr (cmd.clear_step ? clr_addr : col[r]),
      .wdata (cmd.clear_step ? '0 : upd[r]),
      .raddr (col[r]),
      .rdata (rdata[r])
    );
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < ROWS; r++) begin
      if (cmd.load) begin
        val[r] <= rdata[r];
      end else if (cmd.update && sel[r]) begin
        val[r] <= upd[r];
      end
    end
  end

  // row-serial minimum scan
  assign min_last = (row_idx == RIW'(ROWS - 1));
  assign mn_next  = ((row_idx == '0) || (val[row_idx] < mn)) ? val[row_idx] : mn;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_idx <= '0;
    end else if (cmd.load || cmd.update) begin
      row_idx <= '0;
    end else if (cmd.min_step) begin
      row_idx <= row_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.min_step) mn <= mn_next;
  end

  if (COUNT_BITS > RESULT_W) begin : g_sat
    assign est32 = (|mn_next[COUNT_BITS-1:RESULT_W]) ? '1 : mn_next[RESULT_W-1:0];
  end else begin : g_ext
    assign est32 = RESULT_W'(mn_next);
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      result.count_estimate <= '0;
      result.skipped        <= skip;
    end else if (cmd.min_step && min_last) begin
      result.count_estimate <= est32;
      result.skipped        <= 1'b0;
    end
  end

  // clearing sweep after reset, all rows in parallel
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign st.action     = it.action;
  assign st.skip       = skip;
  assign st.min_last   = min_last;
  assign st.clear_last = (clr_addr == CW'(COLS - 1));

endmodule
`default_nettype wire

FILE: rtl/cms_checker.sv
// Port-level checks for the sketch top level, bound into it.
`default_nettype none
module cms_checker
  import cms_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    start,
  input wire logic    busy,
  input wire logic    done,
  input wire result_t result
);

  // result beat only while the item is still owned by the block
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("done without busy");

  // one result beat per item
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // an accepted item keeps the block busy and gives no instant result
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted item did not raise busy");

  // filtered items report a zero estimate
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.skipped) |-> (result.count_estimate == '0))
    else $error("skipped item with nonzero estimate");

endmodule

bind count_min_sketch_update_top cms_checker u_cms_checker (.*);
`default_nettype wire
